### src/ata_bri_pkg.sv
// Shared types and constants of the ATA byte register interface.
`default_nettype none
package ata_bri_pkg;

  localparam int unsigned BufferBytes = 512;
  localparam int unsigned RowBytes    = 4;
  localparam int unsigned RowCount    = BufferBytes / RowBytes;
  localparam int unsigned RowAw       = $clog2(RowCount);
  localparam int unsigned PosW        = $clog2(BufferBytes);
  localparam int unsigned IndexW      = PosW + 1;
  localparam int unsigned RowW        = 8 * RowBytes;

  // identify puts the block count at bytes 114..117 (lanes 2,3 of one row, 0,1 of the next)
  localparam int unsigned IdentOffset = 114;
  localparam logic [RowAw-1:0] IdentRowLo = RowAw'(IdentOffset / RowBytes);
  localparam logic [RowAw-1:0] IdentRowHi = RowAw'(IdentOffset / RowBytes + 1);

  typedef enum logic [1:0] {
    OP_BUS_READ  = 2'd0,
    OP_BUS_WRITE = 2'd1,
    OP_FILL      = 2'd2,
    OP_DRAIN     = 2'd3
  } op_e;

  // task-file register selects (address bits 3..0)
  localparam logic [3:0] REG_DATA   = 4'h8;
  localparam logic [3:0] REG_LBA0   = 4'hb;
  localparam logic [3:0] REG_LBA1   = 4'hc;
  localparam logic [3:0] REG_LBA2   = 4'hd;
  localparam logic [3:0] REG_LBA3   = 4'he;
  localparam logic [3:0] REG_STATUS = 4'hf;

  localparam logic [2:0] WINDOW_BITS = 3'b111;

  localparam logic [7:0] ATA_CMD_READ     = 8'h20;
  localparam logic [7:0] ATA_CMD_WRITE    = 8'h30;
  localparam logic [7:0] ATA_CMD_IDENTIFY = 8'hec;
  localparam logic [7:0] ATA_CMD_SET_FEAT = 8'hef;

  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_DSC = 8'h10;
  localparam logic [7:0] ST_RDY = 8'h40;

  localparam logic [1:0] CFG_DISK_PRESENT  = 2'd0;
  localparam logic [1:0] CFG_WRITE_PROTECT = 2'd1;
  localparam logic [1:0] CFG_BLOCK_COUNT   = 2'd2;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'b001,
    FSM_EXEC  = 3'b010,
    FSM_IDENT = 3'b100
  } fsm_e;

endpackage
`default_nettype wire

### src/ata_bri_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ata_bri_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### src/ata_byte_register_interface_core.sv
// Top level: ATA task-file register interface with a row-organized sector buffer RAM.
// Flow: an item is accepted only in IDLE; its RAM row is read, and in EXEC the result is
//   registered and the row modified/written back once the result register is free;
//   identify with a disk adds the IDENT state for the second block-count row write.
// Reset: asynchronous, clears control, configuration, task-file registers and the per-row valid bits;
//   a row that is not valid reads as zero, so no clearing pass is needed.
`default_nettype none
module ata_byte_register_interface_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // address[7:0], write_data[15:8], buffer_position[24:16], 0
  input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // read_data[7:0], block_read_request[8],
                                           // block_write_request[9], block_address[37:10], 0
  output logic      [0:0]  m_axis_tuser,   // from_rom[0]
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import ata_bri_pkg::*;

  // configuration
  logic        disk_q, wp_q;
  logic [31:0] bcount_q;

  // control / task file
  fsm_e              state_q, state_d;
  logic [IndexW-1:0] index_q, index_d;
  logic              err_q, err_d;
  logic [27:0]       lba_q, lba_d;
  logic [7:0]        lastcmd_q, lastcmd_d;
  logic [RowCount-1:0] valid_q, valid_d;

  // captured item
  logic [1:0]      op_q;
  logic [7:0]      addr_q, wdat_q;
  logic [PosW-1:0] sel_q;

  // result register
  logic        ovalid_q, ovalid_d;
  logic [7:0]  ord_q, ord_d;
  logic        orom_q, orom_d, orreq_q, orreq_d, owreq_q, owreq_d;
  logic [27:0] obaddr_q, obaddr_d;

  // RAM ports
  logic             ram_we, ram_re;
  logic [RowAw-1:0] ram_waddr, ram_raddr;
  logic [RowW-1:0]  ram_wdata, ram_rdata;

  logic            accept, commit;
  logic [PosW-1:0] sel_in;
  logic [RowW-1:0] row_cur, row_mod;
  logic [7:0]      byte_cur, status;
  logic            inwin, idx_ok;
  logic [3:0]      regsel;

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // data port uses the running index, fill/drain the given position
  assign sel_in = (s_axis_tuser == OP_BUS_READ || s_axis_tuser == OP_BUS_WRITE)
                  ? index_q[PosW-1:0] : s_axis_tdata[24:16];
  assign ram_re    = accept;
  assign ram_raddr = sel_in[PosW-1:2];

  ata_bri_ram #(
    .WIDTH(RowW),
    .DEPTH(RowCount)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign row_cur  = valid_q[sel_q[PosW-1:2]] ? ram_rdata : '0;
  assign byte_cur = row_cur[sel_q[1:0]*8 +: 8];

  always_comb begin
    row_mod = row_cur;
    row_mod[sel_q[1:0]*8 +: 8] = wdat_q;
  end

  assign inwin  = (addr_q[7:5] == WINDOW_BITS);
  assign regsel = addr_q[3:0];
  assign idx_ok = !index_q[IndexW-1];
  assign status = ST_RDY | (disk_q ? ST_DSC : 8'h00) |
                  (err_q ? ST_ERR : (idx_ok ? ST_DRQ : 8'h00));
  assign commit = !ovalid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    index_d   = index_q;
    err_d     = err_q;
    lba_d     = lba_q;
    lastcmd_d = lastcmd_q;
    valid_d   = valid_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ord_d     = ord_q;
    orom_d    = orom_q;
    orreq_d   = orreq_q;
    owreq_d   = owreq_q;
    obaddr_d  = obaddr_q;
    ram_we    = 1'b0;
    ram_waddr = sel_q[PosW-1:2];
    ram_wdata = row_mod;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (commit) begin
          state_d  = FSM_IDLE;
          ovalid_d = 1'b1;
          ord_d    = 8'h00;
          orom_d   = 1'b0;
          orreq_d  = 1'b0;
          owreq_d  = 1'b0;
          obaddr_d = '0;
          unique case (op_q)
            OP_BUS_READ: begin
              if (!inwin) begin
                orom_d = 1'b1;
              end else begin
                unique case (regsel)
                  REG_DATA: begin
                    if (idx_ok) begin
                      ord_d   = byte_cur;
                      index_d = index_q + 1'b1;
                    end
                  end
                  REG_LBA0:   ord_d = lba_q[7:0];
                  REG_LBA1:   ord_d = lba_q[15:8];
                  REG_LBA2:   ord_d = lba_q[23:16];
                  REG_LBA3:   ord_d = {4'h0, lba_q[27:24]};
                  REG_STATUS: ord_d = status;
                  default: ;
                endcase
              end
            end
            OP_BUS_WRITE: begin
              if (inwin) begin
                unique case (regsel)
                  REG_DATA: begin
                    if (idx_ok) begin
                      ram_we  = 1'b1;
                      valid_d[sel_q[PosW-1:2]] = 1'b1;
                      index_d = index_q + 1'b1;
                      if (lastcmd_q == ATA_CMD_WRITE && index_q[PosW-1:0] == '1 &&
                          disk_q && !wp_q) begin
                        owreq_d  = 1'b1;
                        obaddr_d = lba_q;
                      end
                    end
                  end
                  REG_LBA0: lba_d[7:0]   = wdat_q;
                  REG_LBA1: lba_d[15:8]  = wdat_q;
                  REG_LBA2: lba_d[23:16] = wdat_q;
                  REG_LBA3: lba_d[27:24] = wdat_q[3:0];
                  REG_STATUS: begin
                    lastcmd_d = wdat_q;
                    unique case (wdat_q)
                      ATA_CMD_READ: begin
                        index_d = '0;
                        if (disk_q) begin
                          orreq_d  = 1'b1;
                          obaddr_d = lba_q;
                        end else begin
                          err_d = 1'b1;
                        end
                      end
                      ATA_CMD_WRITE: begin
                        index_d = '0;
                        err_d   = !(disk_q && !wp_q);
                      end
                      ATA_CMD_IDENTIFY: begin
                        index_d = '0;
                        if (disk_q) begin
                          // drop every row, then place the block count
                          err_d     = 1'b0;
                          valid_d   = '0;
                          valid_d[IdentRowLo] = 1'b1;
                          ram_we    = 1'b1;
                          ram_waddr = IdentRowLo;
                          ram_wdata = {bcount_q[15:0], 16'h0000};
                          state_d   = FSM_IDENT;
                        end else begin
                          err_d = 1'b1;
                        end
                      end
                      ATA_CMD_SET_FEAT: err_d = 1'b0;
                      default:          err_d = 1'b1;
                    endcase
                  end
                  default: ;
                endcase
              end
            end
            OP_FILL: begin
              ram_we = 1'b1;
              valid_d[sel_q[PosW-1:2]] = 1'b1;
            end
            OP_DRAIN: ord_d = byte_cur;
            default: ;
          endcase
        end
      end
      FSM_IDENT: begin
        ram_we    = 1'b1;
        ram_waddr = IdentRowHi;
        ram_wdata = {16'h0000, bcount_q[31:16]};
        valid_d[IdentRowHi] = 1'b1;
        state_d   = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      index_q   <= '0;
      err_q     <= 1'b0;
      lba_q     <= '0;
      lastcmd_q <= '0;
      valid_q   <= '0;
      ovalid_q  <= 1'b0;
      disk_q    <= 1'b0;
      wp_q      <= 1'b0;
      bcount_q  <= '0;
    end else begin
      state_q   <= state_d;
      index_q   <= index_d;
      err_q     <= err_d;
      lba_q     <= lba_d;
      lastcmd_q <= lastcmd_d;
      valid_q   <= valid_d;
      ovalid_q  <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_DISK_PRESENT:  disk_q   <= cfg_data_i[0];
          CFG_WRITE_PROTECT: wp_q     <= cfg_data_i[0];
          CFG_BLOCK_COUNT:   bcount_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      addr_q <= s_axis_tdata[7:0];
      wdat_q <= s_axis_tdata[15:8];
      sel_q  <= sel_in;
    end
    ord_q    <= ord_d;
    orom_q   <= orom_d;
    orreq_q  <= orreq_d;
    owreq_q  <= owreq_d;
    obaddr_q <= obaddr_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, obaddr_q, owreq_q, orreq_q, ord_q};
  assign m_axis_tuser  = orom_q;

endmodule
`default_nettype wire

### sim/ata_bri_checker.sv
// Checker for the ATA byte register interface: predicts every result and compares it.
module ata_bri_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] in_data_i,   // address[7:0], write_data[15:8], buffer_position[24:16]
  input  wire logic [1:0]  in_user_i,   // command[1:0]
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [39:0] out_data_i,  // read_data[7:0], rd req[8], wr req[9], lba[37:10]
  input  wire logic [0:0]  out_user_i,  // from_rom[0]
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);
  import ata_bri_pkg::*;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        from_rom;
    logic        rd_req;
    logic        wr_req;
    logic [27:0] lba;
  } reply_t;

  logic [7:0]        sector_mem [BufferBytes];
  logic [IndexW-1:0] buf_idx;
  logic              err_flag;
  logic [27:0]       lba_reg;
  logic [7:0]        last_cmd;
  logic              disk_on;
  logic              wr_prot;
  logic [31:0]       blk_count;

  reply_t      reply_q [$];
  int unsigned fails;
  int unsigned depth;

  assign errors_o  = fails;
  assign pending_o = depth;

  function automatic logic [7:0] task_file_status();
    logic [7:0] s;
    s = ST_RDY;
    if (disk_on) s |= ST_DSC;
    if (err_flag) s |= ST_ERR;
    else if (buf_idx < BufferBytes) s |= ST_DRQ;
    return s;
  endfunction

  // Applies one item to the shadow task file and returns the reply it produces.
  task automatic run_access(input op_e op, input logic [7:0] addr, input logic [7:0] wdata,
                            input logic [8:0] pos, output reply_t r);
    logic       in_win;
    logic [3:0] sel;
    int         k;
    r      = '0;
    in_win = (addr[7:5] == WINDOW_BITS);
    sel    = addr[3:0];
    case (op)
      OP_BUS_READ: begin
        if (!in_win) begin
          r.from_rom = 1'b1;
        end else begin
          case (sel)
            REG_DATA: begin
              if (buf_idx < BufferBytes) begin
                r.read_data = sector_mem[buf_idx[PosW-1:0]];
                buf_idx     = buf_idx + 1'b1;
              end
            end
            REG_LBA0:   r.read_data = lba_reg[7:0];
            REG_LBA1:   r.read_data = lba_reg[15:8];
            REG_LBA2:   r.read_data = lba_reg[23:16];
            REG_LBA3:   r.read_data = {4'h0, lba_reg[27:24]};
            REG_STATUS: r.read_data = task_file_status();
            default: ;
          endcase
        end
      end
      OP_BUS_WRITE: begin
        if (in_win) begin
          case (sel)
            REG_DATA: begin
              if (buf_idx < BufferBytes) begin
                sector_mem[buf_idx[PosW-1:0]] = wdata;
                buf_idx = buf_idx + 1'b1;
                // last byte of a sector under a write command goes out to storage
                if (last_cmd == ATA_CMD_WRITE && buf_idx == BufferBytes && disk_on && !wr_prot)
                begin
                  r.wr_req = 1'b1;
                  r.lba    = lba_reg;
                end
              end
            end
            REG_LBA0: lba_reg[7:0]   = wdata;
            REG_LBA1: lba_reg[15:8]  = wdata;
            REG_LBA2: lba_reg[23:16] = wdata;
            REG_LBA3: lba_reg[27:24] = wdata[3:0];
            REG_STATUS: begin
              last_cmd = wdata;
              case (wdata)
                ATA_CMD_READ: begin
                  buf_idx = '0;
                  if (disk_on) begin
                    r.rd_req = 1'b1;
                    r.lba    = lba_reg;
                  end else begin
                    err_flag = 1'b1;
                  end
                end
                ATA_CMD_WRITE: begin
                  buf_idx  = '0;
                  err_flag = !(disk_on && !wr_prot);
                end
                ATA_CMD_IDENTIFY: begin
                  buf_idx = '0;
                  if (disk_on) begin
                    for (k = 0; k < BufferBytes; k++) sector_mem[k] = 8'h00;
                    sector_mem[IdentOffset]     = blk_count[7:0];
                    sector_mem[IdentOffset + 1] = blk_count[15:8];
                    sector_mem[IdentOffset + 2] = blk_count[23:16];
                    sector_mem[IdentOffset + 3] = blk_count[31:24];
                    err_flag = 1'b0;
                  end else begin
                    err_flag = 1'b1;
                  end
                end
                ATA_CMD_SET_FEAT: err_flag = 1'b0;
                default:          err_flag = 1'b1;
              endcase
            end
            default: ;
          endcase
        end
      end
      OP_FILL:  sector_mem[pos] = wdata;
      default:  r.read_data = sector_mem[pos];
    endcase
  endtask

  task automatic note_failure(input string what, input reply_t want, input reply_t got);
    fails++;
    if (fails <= 10)
      $display("%0t: %s: expected rd=%02h rom=%0b rreq=%0b wreq=%0b lba=%07h, %s",
               $time, what, want.read_data, want.from_rom, want.rd_req, want.wr_req, want.lba,
               $sformatf("got rd=%02h rom=%0b rreq=%0b wreq=%0b lba=%07h",
                         got.read_data, got.from_rom, got.rd_req, got.wr_req, got.lba));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    reply_t got;
    reply_t want;
    int     k;
    if (!rst_ni) begin
      for (k = 0; k < BufferBytes; k++) sector_mem[k] = 8'h00;
      buf_idx   = '0;
      err_flag  = 1'b0;
      lba_reg   = '0;
      last_cmd  = 8'h00;
      disk_on   = 1'b0;
      wr_prot   = 1'b0;
      blk_count = '0;
      reply_q.delete();
      fails     = 0;
      depth     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DISK_PRESENT:  disk_on   = cfg_data_i[0];
          CFG_WRITE_PROTECT: wr_prot   = cfg_data_i[0];
          CFG_BLOCK_COUNT:   blk_count = cfg_data_i;
          default: ;
        endcase
      end
      // a result always leaves after its item was accepted, so check before predicting
      if (out_valid_i && out_ready_i) begin
        got.read_data = out_data_i[7:0];
        got.rd_req    = out_data_i[8];
        got.wr_req    = out_data_i[9];
        got.lba       = out_data_i[37:10];
        got.from_rom  = out_user_i[0];
        if (reply_q.size() == 0) begin
          note_failure("result with nothing pending", '0, got);
        end else begin
          want = reply_q.pop_front();
          if (got !== want) note_failure("result mismatch", want, got);
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_access(op_e'(in_user_i), in_data_i[7:0], in_data_i[15:8], in_data_i[24:16], want);
        reply_q = {reply_q, want};
      end
      depth = reply_q.size();
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for the ATA byte register interface: stimulus, stalls and verdict.
module tb_top;
  import ata_bri_pkg::*;

  localparam int unsigned IdleLimit = 4000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = '0;
  logic [31:0] cfg_data      = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;

  ata_byte_register_interface_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  ata_bri_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Offers one item in bursts with random gaps; returns at the edge that takes it.
  task automatic send_access(input op_e op, input logic [7:0] addr, input logic [7:0] wdata,
                             input logic [8:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, pos, wdata, addr};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Task-file address; bit 4 is don't-care inside the window, so it is randomized.
  function automatic logic [7:0] win_addr(input logic [3:0] sel);
    return {WINDOW_BITS, 1'($urandom_range(0, 1)), sel};
  endfunction

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input logic disk, input logic wp, input logic [31:0] count);
    int k;
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      case (k)
        0: begin
          cfg_index <= CFG_DISK_PRESENT;
          cfg_data  <= {31'd0, disk};
        end
        1: begin
          cfg_index <= CFG_WRITE_PROTECT;
          cfg_data  <= {31'd0, wp};
        end
        default: begin
          cfg_index <= CFG_BLOCK_COUNT;
          cfg_data  <= count;
        end
      endcase
      do @(negedge clk_i); while (!cfg_ready);
      @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
  endtask

  // One host transaction: LBA setup, a command, then mostly data-port traffic.
  task automatic run_session(input logic [7:0] cmd, input int unsigned len);
    int unsigned k;
    int unsigned pick;
    bit          full;
    bit          writing;
    full    = (len >= BufferBytes);
    writing = (cmd == ATA_CMD_WRITE) ? (full || $urandom_range(0, 7) != 0)
                                     : ($urandom_range(0, 7) == 0);
    for (k = 0; k < 4; k++)
      if (full || $urandom_range(0, 3) != 0)
        send_access(OP_BUS_WRITE, win_addr(4'(REG_LBA0 + k)), 8'($urandom), 9'($urandom));
    send_access(OP_BUS_WRITE, win_addr(REG_STATUS), cmd, 9'($urandom));
    for (k = 0; k < len; k++) begin
      // a full sector stays in one direction so its last byte is what moves the index
      pick = full ? 9 : $urandom_range(0, 9);
      case (pick)
        0: send_access(OP_BUS_READ, win_addr(REG_STATUS), 8'($urandom), 9'($urandom));
        1: send_access($urandom_range(0, 1) ? OP_FILL : OP_DRAIN, 8'($urandom), 8'($urandom),
                       9'($urandom));
        2: send_access(writing ? OP_BUS_READ : OP_BUS_WRITE, win_addr(REG_DATA), 8'($urandom),
                       9'($urandom));
        default: send_access(writing ? OP_BUS_WRITE : OP_BUS_READ, win_addr(REG_DATA),
                             8'($urandom), 9'($urandom));
      endcase
    end
    if ($urandom_range(0, 1) != 0)
      send_access(OP_BUS_READ, win_addr(REG_STATUS), 8'($urandom), 9'($urandom));
    if ($urandom_range(0, 1) != 0)
      send_access(OP_BUS_READ, win_addr(4'(REG_LBA0 + $urandom_range(0, 3))), 8'($urandom),
                  9'($urandom));
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned start;
    int unsigned k;
    int unsigned n;
    logic [7:0]  cmd;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 15) < 2) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          send_access(op_e'(2'($urandom)), 8'($urandom), 8'($urandom), 9'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = ATA_CMD_READ;
          3, 4, 5: cmd = ATA_CMD_WRITE;
          6:       cmd = ATA_CMD_IDENTIFY;
          7:       cmd = ATA_CMD_SET_FEAT;
          default: cmd = 8'($urandom);
        endcase
        run_session(cmd, ($urandom_range(0, 5) == 0) ? $urandom_range(100, 140)
                                                     : $urandom_range(1, 24));
      end
    end
  endtask

  // Receiver: random stall modes, plus one long hold-off to back up the block.
  initial begin : sink
    int unsigned cyc;
    int unsigned seg;
    int unsigned mode;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 120);
      repeat (seg) begin
        @(posedge clk_i);
        cyc++;
        if (cyc >= 1500 && cyc < 1800) begin
          m_axis_tready <= 1'b0;
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= (cyc % 3 == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("ata_byte_register_interface_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // no disk, reset configuration
    send_access(OP_BUS_READ, 8'h00, 8'h00, 9'h000);
    send_access(OP_BUS_READ, 8'hdf, 8'hff, 9'h1ff);
    send_access(OP_BUS_WRITE, 8'h7f, 8'hff, 9'h1ff);
    send_access(OP_BUS_READ, {WINDOW_BITS, 1'b0, REG_STATUS}, 8'h00, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_LBA0}, 8'hff, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b1, REG_LBA1}, 8'h00, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_LBA2}, 8'ha5, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b1, REG_LBA3}, 8'hff, 9'h000);
    send_access(OP_BUS_READ, {WINDOW_BITS, 1'b0, REG_LBA3}, 8'h00, 9'h000);
    send_access(OP_BUS_READ, {WINDOW_BITS, 1'b1, REG_LBA0}, 8'h00, 9'h000);
    send_access(OP_BUS_READ, 8'he0, 8'h00, 9'h000);    // select 0 is unmapped
    send_access(OP_BUS_WRITE, 8'hf9, 8'h77, 9'h000);   // select 9 is unmapped
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_STATUS}, ATA_CMD_READ, 9'h000);
    send_access(OP_BUS_READ, {WINDOW_BITS, 1'b0, REG_STATUS}, 8'h00, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_STATUS}, ATA_CMD_WRITE, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b1, REG_STATUS}, ATA_CMD_IDENTIFY, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_STATUS}, 8'h00, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_STATUS}, ATA_CMD_SET_FEAT, 9'h000);
    send_access(OP_BUS_READ, {WINDOW_BITS, 1'b1, REG_STATUS}, 8'h00, 9'h000);
    send_access(OP_FILL, 8'h00, 8'hff, 9'h000);
    send_access(OP_FILL, 8'hff, 8'h80, 9'h1ff);
    send_access(OP_DRAIN, 8'h00, 8'h00, 9'h1ff);
    send_access(OP_DRAIN, 8'hff, 8'hff, 9'h000);
    send_access(OP_BUS_READ, {WINDOW_BITS, 1'b1, REG_DATA}, 8'h00, 9'h000);
    send_access(OP_BUS_WRITE, {WINDOW_BITS, 1'b0, REG_DATA}, 8'h5a, 9'h000);
    wait_idle();

    // disk mounted, writable, largest block count
    load_config(1'b1, 1'b0, 32'hffff_ffff);
    run_session(ATA_CMD_IDENTIFY, 160);
    run_session(ATA_CMD_WRITE, BufferBytes + 2);
    random_phase(60);
    wait_idle();

    // write protected, empty disk
    load_config(1'b1, 1'b1, 32'h0000_0000);
    random_phase(130);
    wait_idle();

    // no disk
    load_config(1'b0, 1'b0, $urandom);
    random_phase(80);
    wait_idle();

    // disk back, read command with full-sector data-port traffic running past the buffer end
    load_config(1'b1, 1'b0, $urandom);
    run_session(ATA_CMD_READ, BufferBytes + 2);
    random_phase(80);
    wait_idle();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("ata_byte_register_interface_core regression: pass");
    else
      $display("ata_byte_register_interface_core regression: fail");
    $finish;
  end

endmodule
